@@ rtl/srsfd_pkg.sv @@
// Shared types and constants for the span/RLE sprite frame decoder.
// Holds the parser phase encoding, result kinds and the packing of the result word.
// Depends on nothing.
`default_nettype none

package srsfd_pkg;

  // Parser phases, one-hot.
  typedef enum logic [6:0] {
    PH_HDR    = 7'b0000001,
    PH_SPAN   = 7'b0000010,
    PH_RAW    = 7'b0000100,
    PH_RUNHDR = 7'b0001000,
    PH_LIT    = 7'b0010000,
    PH_REP    = 7'b0100000,
    PH_IDLE   = 7'b1000000
  } phase_t;

  // Result kinds carried on out_tuser.
  localparam logic [1:0] KIND_SIZE = 2'd0;
  localparam logic [1:0] KIND_RUN  = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;
  localparam logic [1:0] KIND_RSVD = 2'd3;

  // Header byte positions.
  localparam logic [2:0] BIDX_0 = 3'd0;
  localparam logic [2:0] BIDX_1 = 3'd1;
  localparam logic [2:0] BIDX_2 = 3'd2;
  localparam logic [2:0] BIDX_3 = 3'd3;
  localparam logic [2:0] BIDX_4 = 3'd4;
  localparam logic [2:0] BIDX_5 = 3'd5;

  localparam int unsigned OUT_TDATA_W = 88;

  // Result word layout, highest bits first.
  typedef struct packed {
    logic [5:0]         pad;
    logic signed [16:0] frame_height;
    logic signed [16:0] frame_width;
    logic [7:0]         color_index;
    logic [6:0]         run_count;
    logic signed [15:0] pos_y;
    logic signed [16:0] pos_x;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/span_rle_sprite_frame_decoder.sv @@
// Span/RLE sprite frame decoder, top level.
// A result word is registered in the output register, or in the skid register while the
// output register holds a word not yet taken. Throughput: one byte per cycle while in_tready
// is high; in_tready falls only while both the output and the skid register hold untaken words.
// Reset (rst_n low, synchronous) puts the parser back to expect a frame header and
// empties the output register and the skid register.
`default_nettype none

module span_rle_sprite_frame_decoder (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // Byte stream in.
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [7:0]                         in_tdata,   // [7:0] data_byte
  input  wire logic [0:0]                         in_tuser,   // [0] frame_start
  // Result words out.
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // [16:0] pos_x, [32:17] pos_y, [39:33] run_count, [47:40] color_index,
  // [64:48] frame_width, [81:65] frame_height, [87:82] zero
  output logic [srsfd_pkg::OUT_TDATA_W-1:0]       out_tdata,
  output logic [1:0]                              out_tuser   // [1:0] kind
);

  // Parser state. The whole decode of one byte happens in the cycle in which it is
  // accepted, so no input byte is kept apart from the held low byte of a word.
  srsfd_pkg::phase_t phase_r, phase_nxt;
  logic [2:0]         bidx_r, bidx_nxt;
  logic [7:0]         low_hold_r, low_hold_nxt;
  logic [15:0]        right_ext_r, right_ext_nxt;
  logic [15:0]        left_ext_r, left_ext_nxt;
  logic [15:0]        up_ext_r, up_ext_nxt;
  logic [14:0]        span_len_r, span_len_nxt;
  logic               span_rle_r, span_rle_nxt;
  logic [15:0]        cursor_x_r, cursor_x_nxt;
  logic [15:0]        cursor_y_r, cursor_y_nxt;
  logic signed [16:0] end_x_r, end_x_nxt;
  logic [14:0]        pix_cnt_r, pix_cnt_nxt;
  logic [6:0]         run_len_r, run_len_nxt;

  // Output register and skid register.
  logic                              out_valid_r;
  logic [srsfd_pkg::OUT_TDATA_W-1:0] out_data_r;
  logic [1:0]                        out_kind_r;
  logic                              skid_valid_r;
  logic [srsfd_pkg::OUT_TDATA_W-1:0] skid_data_r;
  logic [1:0]                        skid_kind_r;

  logic               accept_in;
  logic               res_valid;
  logic [1:0]         res_kind;
  srsfd_pkg::result_t res;
  logic               res_fire;

  srsfd_pkg::phase_t  phase_cur;
  logic [2:0]         bidx_cur;
  logic [15:0]        word;
  logic signed [16:0] cursor_sx;
  logic signed [16:0] pix_pos;
  logic [15:0]        cursor_adv;
  logic               more_runs_cur;
  logic               more_runs_adv;
  logic [14:0]        pix_inc;
  logic signed [16:0] frame_w;
  logic signed [16:0] frame_h;
  logic signed [16:0] end_x_new;

  assign in_tready = !skid_valid_r;
  assign accept_in = in_tvalid && in_tready;

  // A byte flagged as frame start always restarts the header parse.
  assign phase_cur = in_tuser[0] ? srsfd_pkg::PH_HDR : phase_r;
  assign bidx_cur  = in_tuser[0] ? srsfd_pkg::BIDX_0 : bidx_r;

  // Little-endian word: the held low byte and this byte as the high byte.
  assign word = {in_tdata, low_hold_r};

  // Shared arithmetic: sign-extended cursor, pixel position, cursor advance after a run,
  // signed end test on present and advanced cursor, pixel step, frame size and span end.
  assign cursor_sx     = $signed({cursor_x_r[15], cursor_x_r});
  assign pix_pos       = cursor_sx + $signed({2'b00, pix_cnt_r});
  assign cursor_adv    = cursor_x_r + {9'd0, run_len_r};
  assign more_runs_cur = cursor_sx < end_x_r;
  assign more_runs_adv = $signed({cursor_adv[15], cursor_adv}) < end_x_r;
  assign pix_inc       = pix_cnt_r + 15'd1;
  assign frame_w       = $signed({right_ext_r[15], right_ext_r})
                       + $signed({left_ext_r[15], left_ext_r}) + 17'sd1;
  assign frame_h       = $signed({up_ext_r[15], up_ext_r})
                       + $signed({word[15], word}) + 17'sd1;
  assign end_x_new     = cursor_sx + $signed({2'b00, span_len_r});

  always_comb begin
    phase_nxt    = phase_r;
    bidx_nxt     = bidx_r;
    low_hold_nxt = low_hold_r;
    right_ext_nxt = right_ext_r;
    left_ext_nxt = left_ext_r;
    up_ext_nxt   = up_ext_r;
    span_len_nxt = span_len_r;
    span_rle_nxt = span_rle_r;
    cursor_x_nxt = cursor_x_r;
    cursor_y_nxt = cursor_y_r;
    end_x_nxt    = end_x_r;
    pix_cnt_nxt  = pix_cnt_r;
    run_len_nxt  = run_len_r;
    res_valid    = 1'b0;
    res_kind     = srsfd_pkg::KIND_SIZE;
    res          = '0;

    if (accept_in) begin
      phase_nxt = phase_cur;
      bidx_nxt  = bidx_cur;
      case (phase_cur)
        srsfd_pkg::PH_HDR: begin
          if (!bidx_cur[0]) begin
            low_hold_nxt = in_tdata;
            bidx_nxt     = bidx_cur + 3'd1;
          end else begin
            case (bidx_cur)
              srsfd_pkg::BIDX_1: begin
                right_ext_nxt = word;
                bidx_nxt      = bidx_cur + 3'd1;
              end
              srsfd_pkg::BIDX_3: begin
                left_ext_nxt = word;
                bidx_nxt     = bidx_cur + 3'd1;
              end
              srsfd_pkg::BIDX_5: begin
                up_ext_nxt = word;
                bidx_nxt   = bidx_cur + 3'd1;
              end
              default: begin
                // Down extent: report the frame size.
                phase_nxt        = srsfd_pkg::PH_SPAN;
                bidx_nxt         = srsfd_pkg::BIDX_0;
                res_valid        = 1'b1;
                res_kind         = srsfd_pkg::KIND_SIZE;
                res.frame_width  = frame_w;
                res.frame_height = frame_h;
              end
            endcase
          end
        end

        srsfd_pkg::PH_SPAN: begin
          if (!bidx_cur[0]) begin
            low_hold_nxt = in_tdata;
            bidx_nxt     = bidx_cur + 3'd1;
          end else begin
            case (bidx_cur)
              srsfd_pkg::BIDX_1: begin
                if (word == 16'd0) begin
                  phase_nxt = srsfd_pkg::PH_IDLE;
                  bidx_nxt  = srsfd_pkg::BIDX_0;
                  res_valid = 1'b1;
                  res_kind  = srsfd_pkg::KIND_END;
                end else begin
                  span_len_nxt = word[15:1];
                  span_rle_nxt = word[0];
                  bidx_nxt     = srsfd_pkg::BIDX_2;
                end
              end
              srsfd_pkg::BIDX_3: begin
                cursor_x_nxt = word + left_ext_r;
                bidx_nxt     = srsfd_pkg::BIDX_4;
              end
              default: begin
                cursor_y_nxt = word + up_ext_r;
                bidx_nxt     = srsfd_pkg::BIDX_0;
                pix_cnt_nxt  = 15'd0;
                if (span_rle_r) begin
                  // The cursor starts below the span end exactly when the length is
                  // not zero.
                  end_x_nxt = end_x_new;
                  phase_nxt = (span_len_r != 15'd0) ? srsfd_pkg::PH_RUNHDR
                                                    : srsfd_pkg::PH_SPAN;
                end else if (span_len_r == 15'd0) begin
                  phase_nxt = srsfd_pkg::PH_SPAN;
                end else begin
                  phase_nxt = srsfd_pkg::PH_RAW;
                end
              end
            endcase
          end
        end

        srsfd_pkg::PH_RAW: begin
          res_valid       = 1'b1;
          res_kind        = srsfd_pkg::KIND_RUN;
          res.pos_x       = pix_pos;
          res.pos_y       = $signed(cursor_y_r);
          res.run_count   = 7'd1;
          res.color_index = in_tdata;
          pix_cnt_nxt     = pix_inc;
          if (pix_inc >= span_len_r) begin
            phase_nxt = srsfd_pkg::PH_SPAN;
            bidx_nxt  = srsfd_pkg::BIDX_0;
          end
        end

        srsfd_pkg::PH_RUNHDR: begin
          run_len_nxt = in_tdata[7:1];
          pix_cnt_nxt = 15'd0;
          if (in_tdata[0]) begin
            phase_nxt = srsfd_pkg::PH_REP;
          end else if (in_tdata[7:1] == 7'd0) begin
            // Empty literal run: the cursor has not moved.
            if (!more_runs_cur) begin
              phase_nxt = srsfd_pkg::PH_SPAN;
              bidx_nxt  = srsfd_pkg::BIDX_0;
            end
          end else begin
            phase_nxt = srsfd_pkg::PH_LIT;
          end
        end

        srsfd_pkg::PH_LIT: begin
          res_valid       = 1'b1;
          res_kind        = srsfd_pkg::KIND_RUN;
          res.pos_x       = pix_pos;
          res.pos_y       = $signed(cursor_y_r);
          res.run_count   = 7'd1;
          res.color_index = in_tdata;
          pix_cnt_nxt     = pix_inc;
          if (pix_inc >= {8'd0, run_len_r}) begin
            cursor_x_nxt = cursor_adv;
            if (more_runs_adv) begin
              phase_nxt = srsfd_pkg::PH_RUNHDR;
            end else begin
              phase_nxt = srsfd_pkg::PH_SPAN;
              bidx_nxt  = srsfd_pkg::BIDX_0;
            end
          end
        end

        srsfd_pkg::PH_REP: begin
          res_valid       = 1'b1;
          res_kind        = srsfd_pkg::KIND_RUN;
          res.pos_x       = cursor_sx;
          res.pos_y       = $signed(cursor_y_r);
          res.run_count   = run_len_r;
          res.color_index = in_tdata;
          cursor_x_nxt    = cursor_adv;
          if (more_runs_adv) begin
            phase_nxt = srsfd_pkg::PH_RUNHDR;
          end else begin
            phase_nxt = srsfd_pkg::PH_SPAN;
            bidx_nxt  = srsfd_pkg::BIDX_0;
          end
        end

        default: begin
          // After the frame end, bytes are dropped until the next frame start.
        end
      endcase
    end
  end

  assign res_fire = accept_in && res_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= srsfd_pkg::PH_HDR;
      bidx_r      <= srsfd_pkg::BIDX_0;
      low_hold_r  <= 8'd0;
      right_ext_r <= 16'd0;
      left_ext_r  <= 16'd0;
      up_ext_r    <= 16'd0;
      span_len_r  <= 15'd0;
      span_rle_r  <= 1'b0;
      cursor_x_r  <= 16'd0;
      cursor_y_r  <= 16'd0;
      end_x_r     <= 17'sd0;
      pix_cnt_r   <= 15'd0;
      run_len_r   <= 7'd0;
    end else begin
      phase_r     <= phase_nxt;
      bidx_r      <= bidx_nxt;
      low_hold_r  <= low_hold_nxt;
      right_ext_r <= right_ext_nxt;
      left_ext_r  <= left_ext_nxt;
      up_ext_r    <= up_ext_nxt;
      span_len_r  <= span_len_nxt;
      span_rle_r  <= span_rle_nxt;
      cursor_x_r  <= cursor_x_nxt;
      cursor_y_r  <= cursor_y_nxt;
      end_x_r     <= end_x_nxt;
      pix_cnt_r   <= pix_cnt_nxt;
      run_len_r   <= run_len_nxt;
    end
  end

  // Output side. A new result goes to the output register when that register is
  // free or being emptied this cycle; otherwise it waits in the skid register, and
  // in_tready stays low until the skid register has moved up.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= res_fire;
      end
    end else if (res_fire) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
        out_kind_r <= skid_kind_r;
      end else begin
        out_data_r <= res;
        out_kind_r <= res_kind;
      end
    end else if (res_fire) begin
      skid_data_r <= res;
      skid_kind_r <= res_kind;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;

  // The skid register only fills behind a waiting output word.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds a word while the output register is empty");

  // The reserved kind code is never produced.
  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser != srsfd_pkg::KIND_RSVD))
    else $error("reserved result kind on the output");

  // Outside header parsing the byte position is always back at zero.
  a_bidx_parked: assert property (@(posedge clk) disable iff (!rst_n)
    ((phase_r != srsfd_pkg::PH_HDR) && (phase_r != srsfd_pkg::PH_SPAN))
      |-> (bidx_r == srsfd_pkg::BIDX_0))
    else $error("byte position not cleared outside header parsing");

endmodule

`default_nettype wire
